@@ src/skt_pkg.sv @@
`timescale 1ns / 1ps
package skt_pkg;

  localparam int DEFAULT_CAPACITY = 128;
  localparam int NAME_WIDTH = 240;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  age;
    logic [NAME_WIDTH-1:0] name;
  } record_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_LOAD   = 4'd1,  // latch request, set idx to 0
    CMD_SCAN   = 4'd2,  // read entry idx + 1, idx unchanged
    CMD_NEXT   = 4'd3,  // idx <= idx + 1, read idx + 1
    CMD_SETTOP = 4'd4,  // idx <= count, read count - 1
    CMD_SHUP   = 4'd5,  // mem[idx] <= rd, idx--, read idx - 2
    CMD_PUT    = 4'd6,  // mem[idx] <= request, count++
    CMD_SHDN   = 4'd7,  // mem[idx] <= rd, idx++, read idx + 2
    CMD_DEC    = 4'd8,  // count--
    CMD_BSRD   = 4'd9,  // idx <= mid, read mid
    CMD_BSHI   = 4'd10, // hi <= mid
    CMD_BSLO   = 4'd11, // lo <= mid + 1
    CMD_INIT   = 4'd12  // lo <= 0, hi <= count
  } cmd_t;

  typedef struct packed {
    logic key_eq;    // read key equals request key
    logic key_gt;    // read key above request key (signed)
    logic idx_end;   // idx == count
    logic idx_last;  // idx + 1 == count
    logic idx_zero;
    logic full;
    logic bs_empty;  // lo >= hi
  } stat_t;

endpackage

@@ src/skt_if.sv @@
`timescale 1ns / 1ps
interface skt_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/skt_datapath.sv @@
`timescale 1ns / 1ps
module skt_datapath
  import skt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int IW = $clog2(CAPACITY + 1),
  parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic     clk,
  input  logic     rst,
  input  cmd_t     cmd,
  input  record_t  req_in,
  output stat_t    stat,
  output record_t  rd_rec,
  output logic [IW-1:0] count,
  output record_t  req
);

  record_t mem [CAPACITY];
  logic [IW-1:0] idx, lo, hi, rd_addr;
  logic [IW:0] mid_sum;
  logic [IW-1:0] mid;
  logic mem_we;
  logic [IW-1:0] wr_addr;
  record_t wr_data;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[IW:1];

  always_comb begin
    rd_addr = idx;
    mem_we  = 1'b0;
    wr_addr = idx;
    wr_data = rd_rec;
    case (cmd)
      CMD_LOAD:   rd_addr = '0;
      CMD_SCAN:   rd_addr = idx + IW'(1);
      CMD_NEXT:   rd_addr = idx + IW'(1);
      CMD_SETTOP: rd_addr = count - IW'(1);
      CMD_SHUP: begin
        mem_we = 1'b1;
        rd_addr = idx - IW'(2);
      end
      CMD_PUT: begin
        mem_we = 1'b1;
        wr_data = req;
      end
      CMD_SHDN: begin
        mem_we = 1'b1;
        rd_addr = idx + IW'(2);
      end
      CMD_BSRD: rd_addr = mid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr[AW-1:0]] <= wr_data;
    rd_rec <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        CMD_PUT: count <= count + IW'(1);
        CMD_DEC: count <= count - IW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        req <= req_in;
        idx <= '0;
      end
      CMD_NEXT:   idx <= idx + IW'(1);
      CMD_SETTOP: idx <= count;
      CMD_SHUP:   idx <= idx - IW'(1);
      CMD_SHDN:   idx <= idx + IW'(1);
      CMD_INIT: begin
        lo <= '0;
        hi <= count;
      end
      CMD_BSRD:   idx <= mid;
      CMD_BSHI:   hi <= idx;
      CMD_BSLO:   lo <= idx + IW'(1);
      default: ;
    endcase
  end

  assign stat.key_eq   = rd_rec.key == req.key;
  assign stat.key_gt   = $signed(rd_rec.key) > $signed(req.key);
  assign stat.idx_end  = idx == count;
  assign stat.idx_last = (idx + IW'(1)) == count;
  assign stat.idx_zero = idx == '0;
  assign stat.full     = count >= IW'(CAPACITY);
  assign stat.bs_empty = lo >= hi;

endmodule

@@ src/skt_ctrl.sv @@
`timescale 1ns / 1ps
module skt_ctrl
  import skt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] res_status,
  output logic       res_hit,
  output cmd_t       cmd,
  input  stat_t      stat
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_SHUP  = 9'b000001000,
    S_SHDN  = 9'b000010000,
    S_BSRD  = 9'b000100000,
    S_BSCMP = 9'b001000000,
    S_BSWT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [1:0] op, status_next;
  logic hit_next, done_next;

  assign in_ready = (state == S_IDLE) && !res_valid;

  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    status_next = ST_OK;
    hit_next = 1'b0;
    done_next = 1'b0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd = CMD_LOAD;
        state_next = S_DISP;
      end
      S_DISP: begin
        case (op)
          OP_INSERT: begin
            if (stat.full) begin
              status_next = ST_FULL;
              done_next = 1'b1;
            end else if (stat.idx_end) begin
              cmd = CMD_SETTOP;
              state_next = S_SHUP;
            end else begin
              state_next = S_SCAN;
            end
          end
          OP_LOOKUP: begin
            cmd = CMD_INIT;
            state_next = S_BSRD;
          end
          OP_DELETE: begin
            if (stat.idx_end) begin
              status_next = ST_NOT_FOUND;
              done_next = 1'b1;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: done_next = 1'b1;
        endcase
      end
      // linear scan, rd_rec holds entry idx
      S_SCAN: begin
        if (stat.key_eq) begin
          if (op == OP_INSERT) begin
            status_next = ST_DUPLICATE;
            done_next = 1'b1;
          end else if (stat.idx_last) begin
            cmd = CMD_DEC;
            done_next = 1'b1;
          end else begin
            // hole stays at idx, fetch the entry above it
            cmd = CMD_SCAN;
            state_next = S_SHDN;
          end
        end else if (stat.idx_last) begin
          if (op == OP_INSERT) begin
            cmd = CMD_SETTOP;
            state_next = S_SHUP;
          end else begin
            status_next = ST_NOT_FOUND;
            done_next = 1'b1;
          end
        end else begin
          cmd = CMD_NEXT;
        end
      end
      // idx is hole, rd_rec holds entry idx-1
      S_SHUP: begin
        if (!stat.idx_zero && stat.key_gt) begin
          cmd = CMD_SHUP;
        end else begin
          cmd = CMD_PUT;
          done_next = 1'b1;
        end
      end
      // idx is hole, rd_rec holds entry idx+1
      S_SHDN: begin
        if (stat.idx_last) begin
          cmd = CMD_DEC;
          done_next = 1'b1;
        end else begin
          cmd = CMD_SHDN;
        end
      end
      S_BSRD: begin
        if (stat.bs_empty) begin
          status_next = ST_NOT_FOUND;
          done_next = 1'b1;
        end else begin
          cmd = CMD_BSRD;
          state_next = S_BSWT;
        end
      end
      S_BSWT: state_next = S_BSCMP;
      S_BSCMP: begin
        if (stat.key_eq) begin
          hit_next = 1'b1;
          done_next = 1'b1;
        end else begin
          cmd = stat.key_gt ? CMD_BSHI : CMD_BSLO;
          state_next = S_BSRD;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (done_next) state_next = S_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready) op <= in_op;
    if (done_next) begin
      res_status <= status_next;
      res_hit <= hit_next;
    end
  end

endmodule

@@ src/sorted_key_table_unit.sv @@
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | opcode, key, age, name_bytes_0_7 .. name_bytes_24_29
// out     | out | status, found_key, found_age, found_name_*, entry_count
// one item at a time; lookup is a binary search over the sorted entries,
// insert and delete a linear scan, bound by the record memory with one read
// and one write port that scans and then shifts one entry per cycle
// synchronous reset empties the table at once; memory is not cleared
// the result register holds until taken; a new item enters once it is taken
module sorted_key_table_unit
  import skt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic clk,
  input logic rst,
  skt_if.sink   in,
  skt_if.source out
);
  localparam int IW = $clog2(CAPACITY + 1);

  cmd_t    cmd;
  stat_t   stat;
  record_t rd_rec, req, req_in;
  logic [IW-1:0] count;
  logic [1:0] res_status;
  logic res_hit, res_valid;

  assign req_in.key  = in.data.key;
  assign req_in.age  = in.data.age;
  assign req_in.name = {in.data.name_bytes_24_29, in.data.name_bytes_16_23,
                        in.data.name_bytes_8_15, in.data.name_bytes_0_7};

  skt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_op(in.data.opcode), .in_ready(in.ready),
    .res_valid, .res_ready(out.ready), .res_status, .res_hit,
    .cmd, .stat
  );

  skt_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .req_in, .stat, .rd_rec, .count, .req
  );

  // rd_rec is held steady once done, result fields decode from it
  assign out.valid                 = res_valid;
  assign out.data.status           = res_status;
  assign out.data.found_key        = res_hit ? rd_rec.key : '0;
  assign out.data.found_age        = res_hit ? rd_rec.age : '0;
  assign out.data.found_name_0_7   = res_hit ? rd_rec.name[63:0] : '0;
  assign out.data.found_name_8_15  = res_hit ? rd_rec.name[127:64] : '0;
  assign out.data.found_name_16_23 = res_hit ? rd_rec.name[191:128] : '0;
  assign out.data.found_name_24_29 = res_hit ? rd_rec.name[239:192] : '0;
  assign out.data.entry_count      = 8'(count);

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= IW'(CAPACITY)) else $error("count above capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !in.ready) else $error("accept while result pending");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data.status)
    && $stable(out.data.found_key) && $stable(out.data.entry_count))
    else $error("result changed while waiting");
endmodule
